// ----- rtl/tpd_pkg.sv -----
package tpd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned PosW      = CoordW + 1;
  localparam int unsigned PressW    = 10;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned FrameLen  = 7;
  localparam int unsigned CountW    = 3;
  localparam int unsigned StartBit  = 7;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [CountW-1:0] LastIdx = CountW'(FrameLen - 1);

  localparam logic [CfgW-1:0] XFullScaleRst = 16'd6000;
  localparam logic [CfgW-1:0] YFullScaleRst = 16'd8192;

  typedef enum logic [0:0] {
    REG_X_FULL_SCALE = 1'b0,
    REG_Y_FULL_SCALE = 1'b1
  } cfg_reg_e;

  // One decoded frame, as handed from the assembler to the report unit.
  typedef struct packed {
    logic              touch;
    logic [CoordW-1:0] raw_x;
    logic [CoordW-1:0] raw_y;
    logic [PressW-1:0] pressure;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/touch_packet_decoder_unit.sv -----
// Touch packet decoder: 7-byte frames in, at most one report out per frame.
// Throughput: one byte per cycle; queue-full stall only if reports back up.
// Path: a frame's last byte is written into the queue at the edge that accepts
// it; the report output register then loads from the queue head once free.
// Reset: byte counter hunts for a start byte, queue empty, release flag clear,
// full-scale registers back to 6000 (X) and 8192 (Y).
module touch_packet_decoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tpd_pkg::ByteW-1:0]         rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              touch_down_o,
  output logic signed [tpd_pkg::PosW-1:0]   pos_x_o,
  output logic signed [tpd_pkg::PosW-1:0]   pos_y_o,
  output logic [tpd_pkg::PressW-1:0]        pressure_o,
  input  logic                              cfg_we_i,
  input  tpd_pkg::cfg_reg_e                 cfg_idx_i,
  input  logic [tpd_pkg::CfgW-1:0]          cfg_wdata_i
);

  logic [tpd_pkg::CfgW-1:0] x_fs_q, y_fs_q;
  logic                     accept, push, pop;
  tpd_pkg::frame_t          frame, head;
  tpd_pkg::q_status_t       q_status;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_fs_q <= tpd_pkg::XFullScaleRst;
      y_fs_q <= tpd_pkg::YFullScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpd_pkg::REG_X_FULL_SCALE: x_fs_q <= cfg_wdata_i;
        tpd_pkg::REG_Y_FULL_SCALE: y_fs_q <= cfg_wdata_i;
        default:                   x_fs_q <= x_fs_q;
      endcase
    end
  end

  tpd_frame_asm u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .frame_o   (frame)
  );

  tpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (frame),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  tpd_report u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_full_scale_i (x_fs_q),
    .y_full_scale_i (y_fs_q),
    .head_i         (head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .touch_down_o   (touch_down_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pressure_o     (pressure_o)
  );

endmodule

// ----- rtl/tpd_frame_asm.sv -----
module tpd_frame_asm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [tpd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        push_o,
  output tpd_pkg::frame_t             frame_o
);

  logic [tpd_pkg::CountW-1:0] count_q, count_d;
  logic                       touch_q;
  logic [6:0]                 body_q [1:5];
  logic                       start;

  assign start = rx_byte_i[tpd_pkg::StartBit];

  // seventh byte closes the frame unless it is itself a start byte
  assign push_o = accept_i && !start && (count_q == tpd_pkg::LastIdx);

  always_comb begin
    frame_o.touch    = touch_q;
    frame_o.raw_x    = {body_q[1], 9'b0} | {7'b0, body_q[2], 2'b0} | {14'b0, rx_byte_i[6:5]};
    frame_o.raw_y    = {body_q[3], 9'b0} | {7'b0, body_q[4], 2'b0} | {14'b0, rx_byte_i[4:3]};
    frame_o.pressure = {rx_byte_i[2:0], body_q[5]};
  end

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      priority if (start) begin
        count_d = 3'd1;
      end else if (count_q == 3'd0) begin
        count_d = 3'd0;
      end else if (count_q == tpd_pkg::LastIdx) begin
        count_d = 3'd0;
      end else begin
        count_d = count_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && start) begin
      touch_q <= rx_byte_i[0];
    end
    for (int i = 1; i <= 5; i++) begin
      if (accept_i && !start && (count_q == 3'(i))) begin
        body_q[i] <= rx_byte_i[6:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tpd_pkg::LastIdx)
    else $error("byte counter out of range");

  a_push_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> count_q == 3'd0)
    else $error("counter not cleared after frame end");
`endif

endmodule

// ----- rtl/tpd_queue.sv -----
module tpd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tpd_pkg::frame_t     data_i,
  input  logic                pop_i,
  output tpd_pkg::frame_t     head_o,
  output tpd_pkg::q_status_t  status_o
);

  tpd_pkg::frame_t            mem_q [tpd_pkg::QDepth];
  logic [tpd_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [tpd_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign status_o.full  = (cnt_q == tpd_pkg::QCntW'(tpd_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == tpd_pkg::QPtrW'(tpd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == tpd_pkg::QPtrW'(tpd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("frame pushed into full queue");
`endif

endmodule

// ----- rtl/tpd_report.sv -----
module tpd_report (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tpd_pkg::CfgW-1:0]      x_full_scale_i,
  input  logic [tpd_pkg::CfgW-1:0]      y_full_scale_i,
  input  tpd_pkg::frame_t               head_i,
  input  tpd_pkg::q_status_t            q_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          touch_down_o,
  output logic signed [tpd_pkg::PosW-1:0]   pos_x_o,
  output logic signed [tpd_pkg::PosW-1:0]   pos_y_o,
  output logic [tpd_pkg::PressW-1:0]    pressure_o
);

  logic                             valid_q;
  logic                             release_sent_q;
  logic                             touch_q;
  logic signed [tpd_pkg::PosW-1:0]  pos_x_q, pos_y_q;
  logic [tpd_pkg::PressW-1:0]       press_q;

  logic out_free, has_press, rep_touch, rep_nothing, rep_lift, emit;

  assign out_free  = !valid_q || !out_stall_i;
  assign pop_o     = !q_status_i.empty && out_free;
  assign has_press = (head_i.pressure != '0);

  assign rep_touch   = head_i.touch && has_press;
  assign rep_nothing = !head_i.touch && !has_press;
  // pen still down but pressure gone: report a release only once
  assign rep_lift    = head_i.touch && !has_press && !release_sent_q;
  assign emit        = rep_touch || rep_nothing || rep_lift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= 1'b0;
      release_sent_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q <= emit;
        if (rep_touch) begin
          release_sent_q <= 1'b0;
        end else if (rep_lift) begin
          release_sent_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      touch_q <= rep_touch;
      pos_x_q <= {1'b0, x_full_scale_i} - {1'b0, head_i.raw_x};
      pos_y_q <= {1'b0, y_full_scale_i} - {1'b0, head_i.raw_y};
      press_q <= rep_touch ? head_i.pressure : '0;
    end
  end

  assign out_valid_o  = valid_q;
  assign touch_down_o = touch_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign pressure_o   = press_q;

`ifndef SYNTHESIS
  a_flag_set_on_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(release_sent_q) |-> $past(pop_o && rep_lift))
    else $error("release flag set without a release report");
`endif

endmodule
